/* design/csrl_pkg.sv */
// Package for the cosine similarity / relative L2 core.
// Shared widths, FSM state type, controller/datapath command and status structs.
`timescale 1ns / 1ps
package csrl_pkg;

	localparam int MAX_ELEMENTS = 65536;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int ACC_W        = 31 + CNT_W;
	localparam int DIFF_W       = 33 + CNT_W;
	localparam int PROD_W       = 2 * ACC_W;
	localparam int WIDE_W       = 2 * ACC_W + 34;
	localparam int COS_BITS     = 16;
	localparam int REL_BITS     = 24;
	localparam int K_W          = $clog2(REL_BITS);
	localparam int COS_SHIFT    = 30;
	localparam int REL_SHIFT    = 32;

	localparam logic [0:0] REG_PASS = 1'b0;
	localparam logic [0:0] REG_WARN = 1'b1;

	localparam logic [1:0] VERDICT_PASS  = 2'd0;
	localparam logic [1:0] VERDICT_WARN  = 2'd1;
	localparam logic [1:0] VERDICT_FATAL = 2'd2;

	localparam logic signed [15:0] PASS_RESET = 16'sd32440;
	localparam logic signed [15:0] WARN_RESET = 16'sd31130;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_LD_NORM,
		ST_W_NORM,
		ST_LD_DOT,
		ST_W_DOT,
		ST_LD_COS,
		ST_W_COS,
		ST_LD_REL,
		ST_W_REL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic acc;
		logic mul_norm;
		logic mul_dot;
		logic root_cos;
		logic root_rel;
		logic cos_save;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic root_busy;
		logic out_free;
	} sts_t;

endpackage

/* design/csrl_ctrl.sv */
// Controller FSM: streams items into the sums, then sequences the end-of-vector math.
// Depends on csrl_pkg.
`timescale 1ns / 1ps
module csrl_ctrl import csrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_ACC: begin
				if (in_valid && in_last) state_nx = ST_LD_NORM;
			end
			ST_LD_NORM: state_nx = ST_W_NORM;
			ST_W_NORM: begin
				if (!sts.mul_busy) state_nx = ST_LD_DOT;
			end
			ST_LD_DOT: state_nx = ST_W_DOT;
			ST_W_DOT: begin
				if (!sts.mul_busy) state_nx = ST_LD_COS;
			end
			ST_LD_COS: state_nx = ST_W_COS;
			ST_W_COS: begin
				if (!sts.root_busy) state_nx = ST_LD_REL;
			end
			ST_LD_REL: state_nx = ST_W_REL;
			ST_W_REL: begin
				if (!sts.root_busy) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) state_nx = ST_ACC;
			end
			default: state_nx = ST_ACC;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready = 1'b1;
				cmd.acc  = in_valid;
			end
			ST_LD_NORM: cmd.mul_norm = 1'b1;
			ST_LD_DOT:  cmd.mul_dot  = 1'b1;
			ST_LD_COS:  cmd.root_cos = 1'b1;
			ST_LD_REL: begin
				cmd.cos_save = 1'b1;
				cmd.root_rel = 1'b1;
			end
			ST_EMIT:    cmd.out_load = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* design/csrl_dp.sv */
// Datapath: running sums, shift-add multiplier, bit-serial root search, result register.
// Depends on csrl_pkg.
`timescale 1ns / 1ps
module csrl_dp import csrl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic signed [15:0]    engine_value,
	input  logic signed [15:0]    truth_value,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    cosine,
	output logic [REL_BITS-1:0]   relative_error,
	output logic [1:0]            verdict,
	output logic [CNT_W-1:0]      element_count
);

	logic signed [15:0]       pass_thr_q, warn_thr_q;
	logic signed [ACC_W-1:0]  dot_q;
	logic [ACC_W-1:0]         en_q, tn_q;
	logic [DIFF_W-1:0]        df_q;
	logic [CNT_W-1:0]         cnt_q;

	logic signed [31:0]       p_ab, p_aa, p_bb;
	logic signed [16:0]       d;
	logic signed [33:0]       p_dd;
	logic                     room;
	logic [ACC_W-1:0]         mag;

	logic [PROD_W-1:0]        mul_a_q, mul_p_q, pn_q;
	logic [ACC_W-1:0]         mul_b_q;

	logic [WIDE_W-1:0]        s_q, u_q, v_q, rm_q, cand;
	logic [REL_BITS-1:0]      q_q;
	logic [K_W-1:0]           k_q;
	logic                     root_busy_q, take;

	logic signed [15:0]       cos_q, cos_nx;
	logic [COS_BITS-1:0]      qc;
	logic                     out_valid_q;
	logic [1:0]               verd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_thr_q <= PASS_RESET;
			warn_thr_q <= WARN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_PASS) pass_thr_q <= cfg_data;
			else                       warn_thr_q <= cfg_data;
		end
	end

	assign p_ab = engine_value * truth_value;
	assign p_aa = engine_value * engine_value;
	assign p_bb = truth_value * truth_value;
	assign d    = {engine_value[15], engine_value} - {truth_value[15], truth_value};
	assign p_dd = d * d;
	assign room = cnt_q < CNT_W'(MAX_ELEMENTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			en_q  <= '0;
			tn_q  <= '0;
			df_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.out_load) begin
			dot_q <= '0;
			en_q  <= '0;
			tn_q  <= '0;
			df_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.acc && room) begin
			dot_q <= dot_q + ACC_W'(p_ab);
			en_q  <= en_q + {{(ACC_W-31){1'b0}}, p_aa[30:0]};
			tn_q  <= tn_q + {{(ACC_W-31){1'b0}}, p_bb[30:0]};
			df_q  <= df_q + {{(DIFF_W-33){1'b0}}, p_dd[32:0]};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign mag = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);

	// shift-add multiplier, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_norm) begin
			mul_a_q <= {{ACC_W{1'b0}}, en_q};
			mul_b_q <= tn_q;
			mul_p_q <= '0;
		end else if (cmd.mul_dot) begin
			pn_q    <= mul_p_q;
			mul_a_q <= {{ACC_W{1'b0}}, mag};
			mul_b_q <= mag;
			mul_p_q <= '0;
		end else if (mul_b_q != '0) begin
			if (mul_b_q[0]) mul_p_q <= mul_p_q + mul_a_q;
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end
	end

	// greedy root: largest q with q*q*P <= M; S = q^2 P, U = T 2^(k+1), V = P 2^(2k)
	assign cand = s_q + u_q + v_q;
	assign take = cand <= rm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_busy_q <= 1'b0;
		end else if (cmd.root_cos || cmd.root_rel) begin
			root_busy_q <= 1'b1;
		end else if (root_busy_q && k_q == '0) begin
			root_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_cos) begin
			s_q  <= '0;
			u_q  <= '0;
			v_q  <= WIDE_W'(pn_q) << (2 * (COS_BITS - 1));
			rm_q <= WIDE_W'(mul_p_q) << COS_SHIFT;
			q_q  <= '0;
			k_q  <= K_W'(COS_BITS - 1);
		end else if (cmd.root_rel) begin
			s_q  <= '0;
			u_q  <= '0;
			v_q  <= WIDE_W'(tn_q) << (2 * (REL_BITS - 1));
			rm_q <= WIDE_W'(df_q) << REL_SHIFT;
			q_q  <= '0;
			k_q  <= K_W'(REL_BITS - 1);
		end else if (root_busy_q) begin
			if (take) begin
				s_q      <= cand;
				u_q      <= (u_q >> 1) + v_q;
				q_q[k_q] <= 1'b1;
			end else begin
				u_q <= u_q >> 1;
			end
			v_q <= v_q >> 2;
			if (k_q != '0) k_q <= k_q - 1'b1;
		end
	end

	assign qc = q_q[COS_BITS-1:0];

	always_comb begin
		if (en_q == '0 || tn_q == '0) begin
			cos_nx = '0;
		end else if (dot_q[ACC_W-1]) begin
			cos_nx = 16'(-$signed({1'b0, qc}));
		end else if (qc[COS_BITS-1]) begin
			cos_nx = 16'sd32767;
		end else begin
			cos_nx = $signed(qc);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cos_save) cos_q <= cos_nx;
	end

	always_comb begin
		if (cos_q >= pass_thr_q)      verd = VERDICT_PASS;
		else if (cos_q >= warn_thr_q) verd = VERDICT_WARN;
		else                          verd = VERDICT_FATAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cosine         <= cos_q;
			relative_error <= (tn_q == '0) ? '0 : q_q;
			verdict        <= verd;
			element_count  <= cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.mul_busy  = mul_b_q != '0;
	assign sts.root_busy = root_busy_q;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

/* design/cosine_similarity_rel_l2_core.sv */
// Throughput: one item per cycle within a vector. After the last item no item is taken
// until the shift-add multiplier (two passes) and the bit-serial root (two passes)
// finish and the result has been loaded into a free output register.
// Reset: async active low; clears sums, count, FSM, output valid; thresholds to defaults.
// Top level; instantiates csrl_ctrl and csrl_dp, uses csrl_pkg.
`timescale 1ns / 1ps
module cosine_similarity_rel_l2_core import csrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // engine_value[15:0], truth_value[31:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // cosine[15:0], relative_error[39:16], verdict[41:40],
	                               // element_count[58:42], zero fill
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t                cmd;
	sts_t                sts;
	logic signed [15:0]  cosine;
	logic [REL_BITS-1:0] relative_error;
	logic [1:0]          verdict;
	logic [CNT_W-1:0]    element_count;

	csrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csrl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.engine_value   (s_tdata[15:0]),
		.truth_value    (s_tdata[31:16]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.cosine         (cosine),
		.relative_error (relative_error),
		.verdict        (verdict),
		.element_count  (element_count)
	);

	assign m_tdata = 64'({element_count, verdict, relative_error, cosine});

endmodule

/* design/csrl_checker.sv */
// Port-level checker for cosine_similarity_rel_l2_core, attached by bind.
// Depends on nothing beyond the top-level ports.
`timescale 1ns / 1ps
module csrl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("item taken right after last item");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[41:40] != 2'd3)
		else $error("bad verdict code");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[58:42] != 17'd0 && m_tdata[63:59] == 5'd0)
		else $error("bad element count or fill");

endmodule

bind cosine_similarity_rel_l2_core csrl_checker u_csrl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/tb.sv */
// Self-checking bench for cosine_similarity_rel_l2_core: streams element pairs and
// checks each per-vector result against an exact integer predictor kept here.
// Depends on csrl_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb;
	import csrl_pkg::*;

	typedef struct packed {
		logic signed [15:0] engine;
		logic signed [15:0] truth;
		logic               last;
	} pair_t;

	typedef struct packed {
		logic signed [15:0] cosine;
		logic [23:0]        rel_err;
		logic [1:0]         verdict;
		logic [16:0]        count;
	} score_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_PASS;
	logic [15:0] cfg_data = '0;

	cosine_similarity_rel_l2_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pair_t  pair_q[$];
	score_t score_q[$];
	int     errors = 0;
	int     cycles = 0;
	bit     taken = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     rx_hold = 0;
	bit     rx_long_req = 0;
	int     rx_mode = 0;

	// predictor state
	logic signed [15:0] pass_thr = PASS_RESET;
	logic signed [15:0] warn_thr = WARN_RESET;
	longint             dot_acc = 0;
	longint             eng_acc = 0;
	longint             tru_acc = 0;
	longint             dif_acc = 0;
	int                 n_acc = 0;

	// largest q in [0, top] with q*q*den <= num
	function automatic longint root_search(longint top, logic [255:0] den, logic [255:0] num);
		longint lo, hi, mid;
		logic [255:0] q2;
		lo = 0;
		hi = top;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			q2 = 256'(mid) * 256'(mid);
			if (q2 * den <= num) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	task automatic score_pair(pair_t p);
		longint a, b, d, mag, q;
		score_t r;
		a = p.engine;
		b = p.truth;
		if (n_acc < MAX_ELEMENTS) begin
			d = a - b;
			dot_acc += a * b;
			eng_acc += a * a;
			tru_acc += b * b;
			dif_acc += d * d;
			n_acc++;
		end
		if (p.last) begin
			r.cosine = 0;
			if (eng_acc != 0 && tru_acc != 0) begin
				mag = dot_acc < 0 ? -dot_acc : dot_acc;
				q = root_search(32768, 256'(eng_acc) * 256'(tru_acc),
				                (256'(mag) * 256'(mag)) << 30);
				if (dot_acc < 0) r.cosine = 16'(-q);
				else r.cosine = q > 32767 ? 16'sd32767 : 16'(q);
			end
			r.rel_err = 0;
			if (tru_acc != 0)
				r.rel_err = 24'(root_search(24'hFFFFFF, 256'(tru_acc), 256'(dif_acc) << 32));
			if (r.cosine >= pass_thr) r.verdict = VERDICT_PASS;
			else if (r.cosine >= warn_thr) r.verdict = VERDICT_WARN;
			else r.verdict = VERDICT_FATAL;
			r.count = 17'(n_acc);
			score_q.push_back(r);
			dot_acc = 0;
			eng_acc = 0;
			tru_acc = 0;
			dif_acc = 0;
			n_acc = 0;
		end
	endtask

	// sender: accept at posedge, drive at negedge
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			score_pair(pair_q[0]);
			void'(pair_q.pop_front());
			taken = 1;
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || taken) begin
			taken = 0;
			if (gap_left > 0 || pair_q.size() == 0) begin
				if (gap_left > 0) gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= {pair_q[0].truth, pair_q[0].engine};
				s_tlast  <= pair_q[0].last;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
					gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (rx_long_req) begin
			rx_long_req = 0;
			rx_hold = 600;
		end
		if ($urandom_range(0, 99) == 0) rx_mode = $urandom_range(0, 2);
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 3) != 0;
				default: m_tready <= $urandom_range(0, 3) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		score_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[39:16], m_tdata[41:40], m_tdata[58:42]};
			if (score_q.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors++;
			end else begin
				want = score_q.pop_front();
				if (got.cosine !== want.cosine) begin
					$error("cosine exp %0d got %0d", want.cosine, got.cosine);
					errors++;
				end
				if (got.rel_err !== want.rel_err) begin
					$error("relative_error exp %0d got %0d", want.rel_err, got.rel_err);
					errors++;
				end
				if (got.verdict !== want.verdict) begin
					$error("verdict exp %0d got %0d", want.verdict, got.verdict);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("element_count exp %0d got %0d", want.count, got.count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("cosine_similarity_rel_l2_core: mismatch");
			$finish;
		end
	end

	task automatic push_pair(int e, int t, bit l);
		pair_t p;
		p.engine = 16'(e);
		p.truth  = 16'(t);
		p.last   = l;
		pair_q.push_back(p);
	endtask

	task automatic drain();
		wait (pair_q.size() == 0 && score_q.size() == 0);
		repeat (160) @(posedge clk);
	endtask

	task automatic write_thr(logic [0:0] idx, int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 16'(v);
		if (idx == REG_PASS) pass_thr = 16'(v);
		else warn_thr = 16'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random vector: near-matching or near-negated pairs, some noise and extremes
	task automatic push_vector();
		int len, kind, e, t;
		len  = $urandom_range(0, 9) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 12);
		kind = $urandom_range(0, 4);
		for (int i = 0; i < len; i++) begin
			e = $signed(16'($urandom));
			case (kind)
				0: t = $signed(16'($urandom));
				1: t = e + $signed(5'($urandom));
				2: t = e + $signed(10'($urandom));
				3: t = ($urandom_range(0, 1) ? -32768 : 32767);
				default: t = -e + $signed(4'($urandom));
			endcase
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			if (kind == 3 && $urandom_range(0, 1)) e = 0;
			push_pair(e, t, i == len - 1);
		end
	endtask

	initial begin
		int thr[5][2];
		int nv;
		thr = '{'{32440, 31130}, '{32767, -32768}, '{-32768, 32767},
		        '{32700, 30000}, '{0, 0}};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		push_pair(32767, 32767, 1);
		push_pair(-32768, -32768, 1);
		push_pair(-32768, 32767, 1);
		push_pair(0, 1234, 1);
		push_pair(1234, 0, 1);
		push_pair(0, 0, 1);
		push_pair(32767, 1, 1);
		push_pair(-32768, 1, 1);
		push_pair(100, 100, 0);
		push_pair(-100, 100, 1);
		push_pair(256, -256, 0);
		push_pair(-1, 1, 0);
		push_pair(32767, -32768, 1);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 3) begin
				write_thr(REG_PASS, $urandom_range(30000, 32767));
				write_thr(REG_WARN, $urandom_range(20000, 32767));
			end else begin
				write_thr(REG_PASS, thr[ph][0]);
				write_thr(REG_WARN, thr[ph][1]);
			end
			nv = 0;
			while (nv < 260) begin
				push_vector();
				nv = pair_q.size();
			end
			if (ph == 1) begin
				@(negedge clk);
				rx_long_req = 1;
			end
			drain();
		end

		if (errors == 0)
			$display("cosine_similarity_rel_l2_core: match");
		else
			$display("cosine_similarity_rel_l2_core: mismatch");
		$finish;
	end
endmodule
